// ===== src/spq_pkg.sv =====
package spq_pkg;

  // Default number of entries held by the queue.
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // Width of the fill field on the result.
  localparam int unsigned FILL_W = 5;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Input transaction.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
    logic        [31:0] tag;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0]       out_tag;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } rsp_t;

  // One held entry.
  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] tag;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_ctl_t;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_ins,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ins
);
  import spq_pkg::*;

  // The new key belongs at or before this cell when the cell is empty or
  // its key is not smaller than the new one. Across the chain this flag is
  // monotone, so the first cell raising it is the insertion point.
  assign ins = !occupied || !(entry.key < ctl.item.key);

  // A push shifts entries at and after the insertion point one cell to the
  // right; a pop shifts every entry one cell to the left.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (left_ins) begin
        entry <= left_entry;
      end else if (ins) begin
        entry <= ctl.item;
      end
    end else if (ctl.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// rsp is registered; a result shows the cycle after its request is accepted.
// Throughput: one push or pop per cycle unless req_stall; each cell compares
// its own key with the incoming key and shifts in the same cycle.
// req_stall is raised only while a result waits on a stalled rsp.
// Reset (rst, synchronous, active high) empties the queue and drops rsp_valid.
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             is_full;
  logic             is_empty;
  cell_ctl_t        ctl;
  entry_t           cell_entry [CAPACITY];
  logic             cell_ins   [CAPACITY];
  rsp_t             rsp_next;

  // A new transaction is taken unless a finished result is held up.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // Command to the chain; dropped pushes and empty pops leave it untouched.
  always_comb begin
    ctl.push = accept && (req.op == OP_PUSH) && !is_full;
    ctl.pop  = accept && (req.op == OP_POP) && !is_empty;
    ctl.item = '{key: req.key, tag: req.tag};
  end

  // Row of cells, head at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_ins;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_ins   = 1'b0;
      assign left_entry = ctl.item;
    end else begin : g_body
      assign left_ins   = cell_ins[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count),
      .left_ins    (left_ins),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .ins         (cell_ins[i])
    );
  end

  // Entry count and the result of the current transaction.
  always_comb begin
    count_next       = count;
    rsp_next.out_tag = '0;
    rsp_next.status  = ST_PUSHED;
    if (req.op == OP_PUSH) begin
      if (is_full) begin
        rsp_next.status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        rsp_next.status = ST_EMPTY;
      end else begin
        count_next       = count - CNT_W'(1);
        rsp_next.out_tag = cell_entry[0].tag;
        rsp_next.status  = ST_POPPED;
      end
    end
    rsp_next.fill = FILL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/spq_checker.sv =====
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  // Every accepted transaction shows its result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted transaction gave no result");

  // Input is held back only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled without a held result");

  // A result held by the receiver does not change.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Only a pop carries a tag, and an empty pop leaves nothing held.
  a_rsp_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_POPPED |->
      rsp.out_tag == '0 && (rsp.status != ST_EMPTY || rsp.fill == '0))
    else $error("result fields inconsistent with status");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

// ===== tb/sv/sorted_priority_queue_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int unsigned CAP = DEFAULT_CAPACITY;

  // One queued stimulus transaction; wait_drain holds it back until every
  // outstanding result has been returned.
  typedef struct {
    req_t req;
    bit   wait_drain;
  } stim_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the sorted store, head at index 0.
  entry_t held [CAP];
  int unsigned held_count = 0;

  stim_t stim_q[$];
  rsp_t rsp_due[$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic hold_rsp = 1'b0;
  logic no_idle = 1'b0;

  sorted_priority_queue_core #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Applies one transaction to the shadow queue and returns its result.
  function automatic rsp_t shadow_update(req_t r);
    rsp_t res;
    int unsigned pos;
    res.out_tag = '0;
    if (r.op == OP_PUSH) begin
      if (held_count >= CAP) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && $signed(held[pos].key) < $signed(r.key)) pos++;
        for (int unsigned i = held_count; i > pos; i--) held[i] = held[i - 1];
        held[pos].key = r.key;
        held[pos].tag = r.tag;
        held_count++;
        res.status = ST_PUSHED;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_tag = held[0].tag;
        for (int unsigned i = 1; i < held_count; i++) held[i - 1] = held[i];
        held_count--;
        res.status = ST_POPPED;
      end
    end
    res.fill = held_count[FILL_W-1:0];
    return res;
  endfunction

  // Idle length: mostly none, sometimes short, rarely a long stretch.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keys are drawn so that equal keys, the signed extremes and the whole
  // bit range all turn up often.
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 55) return 32'($signed($urandom_range(0, 6)) - 3);
    if (r < 70) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h8000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h7FFF_FFFE;
        4: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return {16'($signed($urandom_range(0, 200)) - 100), 16'($urandom)};
  endfunction

  function automatic void add_item(op_t op, logic [31:0] key, logic [31:0] tag, bit drain);
    stim_t s;
    s.req.op = op;
    s.req.key = key;
    s.req.tag = tag;
    s.wait_drain = drain;
    stim_q.push_back(s);
  endfunction

  function automatic void report_failure(string what, rsp_t want, rsp_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%s: got tag %h status %0d fill %0d, want tag %h status %0d fill %0d",
               what, got.out_tag, got.status, got.fill, want.out_tag, want.status,
               want.fill);
  endfunction

  // Stimulus: a short directed sequence, then phases of random traffic with
  // a varying push/pop mix so that the queue runs both full and empty.
  initial begin
    int unsigned remaining;
    int unsigned phase_len;
    int unsigned push_pct;
    int unsigned phase_no;
    bit drain;

    // Pop on an empty queue.
    add_item(OP_POP, 32'h0, 32'h0, 1'b0);
    // Signed extremes, equal keys and small keys either side of zero.
    add_item(OP_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_PUSH, 32'h8000_0000, 32'h0000_0000, 1'b0);
    add_item(OP_PUSH, 32'h0000_0000, 32'h0000_0001, 1'b0);
    add_item(OP_PUSH, 32'h0000_0000, 32'h0000_0002, 1'b0);
    add_item(OP_PUSH, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
    add_item(OP_PUSH, 32'h0000_0001, 32'h5555_5555, 1'b0);
    // Drain everything, ending with another pop on empty.
    for (int i = 0; i < 7; i++) add_item(OP_POP, $urandom, $urandom, 1'b0);

    remaining = 2000;
    phase_no = 0;
    while (remaining > 0) begin
      phase_len = $urandom_range(100, 250);
      if (phase_len > remaining) phase_len = remaining;
      case (phase_no)
        0: push_pct = 95;
        1: push_pct = 20;
        default: begin
          case ($urandom_range(0, 3))
            0: push_pct = 20;
            1: push_pct = 50;
            2: push_pct = 80;
            default: push_pct = 95;
          endcase
        end
      endcase
      drain = (phase_no == 1) || ($urandom_range(0, 2) == 0);
      for (int unsigned i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          add_item(OP_PUSH, pick_key(), $urandom, drain && i == 0);
        else
          add_item(OP_POP, $urandom, $urandom, drain && i == 0);
      end
      remaining -= phase_len;
      phase_no++;
    end
  end

  // Driver: offers queued transactions, predicting each one as it is taken.
  always @(posedge clk) begin
    stim_t next_s;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        rsp_due.push_back(shadow_update(req));
        n_accepted++;
        gap_left = pick_idle();
      end
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (stim_q.size() > 0 &&
                   !(stim_q[0].wait_drain && rsp_due.size() > 0)) begin
        next_s = stim_q.pop_front();
        req <= next_s.req;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each returned transaction against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          want = '0;
          report_failure("unexpected result", want, rsp);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.out_tag !== want.out_tag || rsp.status !== want.status ||
              rsp.fill !== want.fill)
            report_failure("mismatch", want, rsp);
        end
      end
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_idle();
      end
    end
  end

  // Alternating stretches with and without idling on either side.
  initial begin
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk);
      no_idle <= 1'b1;
      repeat ($urandom_range(50, 200)) @(posedge clk);
      no_idle <= 1'b0;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the block
  // backs up and stalls its input.
  initial begin
    while (n_accepted < 300) @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // End of run: wait for the stimulus and all results, then give the verdict.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    while (stim_q.size() > 0 || req_valid) @(posedge clk);
    while (rsp_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && rsp_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
src/spq_checker.sv
tb/sv/sorted_priority_queue_core_tb.sv
